FILE: rtl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants and register indexes of the ray/triangle intersection test.
// ----------------------------------------------------------------------------
package rti_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	typedef enum logic [2:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Y   = 3'd1,
		REG_ORIGIN_Z   = 3'd2,
		REG_DIR_X      = 3'd3,
		REG_DIR_Y      = 3'd4,
		REG_DIR_Z      = 3'd5,
		REG_BACKFACE   = 3'd6,
		REG_UNUSED     = 3'd7
	} reg_idx_t;

	// geometry result handed to the divider
	typedef struct packed {
		logic valid;
		logic hit;
		logic zero_div;
	} geom_flags_t;

endpackage

FILE: rtl/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Pipeline: five geometry stages, one divider stage per quotient bit, one
// output register.
// Throughput: one triangle item per cycle; the whole pipe holds while the
// output item waits. Reset clears all valid bits and loads the ray registers
// with origin 0, direction (0, 0, 1.0), backface rejection on.
// ----------------------------------------------------------------------------
module ray_triangle_intersect import rti_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	localparam int DW  = (COORD_WIDTH > 32) ? 64 : 32,
	localparam int AW  = (COORD_WIDTH > 32) ? 6 : 5,
	localparam int SIW = ((9 * COORD_WIDTH + 7) / 8) * 8,
	localparam int MOW = ((COORD_WIDTH + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
	input  logic [SIW-1:0] s_tdata,
	output logic           m_tvalid,
	input  logic           m_tready,
	// distance
	output logic [MOW-1:0] m_tdata,
	// hit, zero_divisor
	output logic [1:0]     m_tuser,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [AW-1:0]  paddr,
	input  logic [DW-1:0]  pwdata,
	output logic [DW-1:0]  prdata,
	output logic           pready
);

	localparam int CW = COORD_WIDTH;
	localparam int SH = AW - 3;

	logic [2:0][CW-1:0] origin_q, dir_q;
	logic               backface_q;
	logic [2:0]         ridx;
	logic               ce;

	assign pready = 1'b1;
	assign ridx   = paddr[AW-1:SH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q   <= '0;
			dir_q      <= {CW'(1) << FRAC_BITS, CW'(0), CW'(0)};
			backface_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && (paddr[SH-1:0] == '0)) begin
			case (reg_idx_t'(ridx))
				REG_ORIGIN_X: origin_q[0] <= pwdata[CW-1:0];
				REG_ORIGIN_Y: origin_q[1] <= pwdata[CW-1:0];
				REG_ORIGIN_Z: origin_q[2] <= pwdata[CW-1:0];
				REG_DIR_X:    dir_q[0]    <= pwdata[CW-1:0];
				REG_DIR_Y:    dir_q[1]    <= pwdata[CW-1:0];
				REG_DIR_Z:    dir_q[2]    <= pwdata[CW-1:0];
				REG_BACKFACE: backface_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(ridx))
			REG_ORIGIN_X: prdata = DW'($signed(origin_q[0]));
			REG_ORIGIN_Y: prdata = DW'($signed(origin_q[1]));
			REG_ORIGIN_Z: prdata = DW'($signed(origin_q[2]));
			REG_DIR_X:    prdata = DW'($signed(dir_q[0]));
			REG_DIR_Y:    prdata = DW'($signed(dir_q[1]));
			REG_DIR_Z:    prdata = DW'($signed(dir_q[2]));
			REG_BACKFACE: prdata = DW'(backface_q);
			default:      prdata = '0;
		endcase
	end

	logic [2:0][CW-1:0] va, vb, vc;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = s_tdata[i*CW +: CW];
			vb[i] = s_tdata[(3+i)*CW +: CW];
			vc[i] = s_tdata[(6+i)*CW +: CW];
		end
	end

	assign ce       = !m_tvalid || m_tready;
	assign s_tready = ce;

	geom_flags_t   gflags, oflags;
	logic [CW-1:0] num, den, distance;

	rti_geom #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_geom (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_valid(s_tvalid),
		.va(va), .vb(vb), .vc(vc), .origin(origin_q), .dir(dir_q),
		.allow_backface(backface_q), .flags(gflags), .num(num), .den(den)
	);

	rti_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_flags(gflags),
		.num(num), .den(den), .out_flags(oflags), .distance(distance)
	);

	assign m_tvalid = oflags.valid;
	assign m_tdata  = MOW'(distance);
	assign m_tuser  = {oflags.zero_div, oflags.hit};

endmodule

FILE: rtl/rti_geom.sv
// ----------------------------------------------------------------------------
// rti_geom
// Five-stage datapath: edges, cross products, dot products and the
// inside / facing tests. Products are registered before being scaled.
// ----------------------------------------------------------------------------
module rti_geom import rti_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ce,
	input  logic                        in_valid,
	input  logic [2:0][COORD_WIDTH-1:0] va,
	input  logic [2:0][COORD_WIDTH-1:0] vb,
	input  logic [2:0][COORD_WIDTH-1:0] vc,
	input  logic [2:0][COORD_WIDTH-1:0] origin,
	input  logic [2:0][COORD_WIDTH-1:0] dir,
	input  logic                        allow_backface,
	output geom_flags_t                 flags,
	output logic [COORD_WIDTH-1:0]      num,
	output logic [COORD_WIDTH-1:0]      den
);

	localparam int CW = COORD_WIDTH;
	localparam int PW = 2 * CW;
	localparam logic [PW-1:0] HALF = PW'(1) << (CW - 1);

	function automatic logic [CW-1:0] sat1(input logic signed [CW:0] x);
		logic [CW-1:0] r;
		if (x[CW] != x[CW-1])
			r = x[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		else
			r = x[CW-1:0];
		return r;
	endfunction

	function automatic logic [CW-1:0] sat2(input logic signed [CW+1:0] x);
		logic [CW-1:0] r;
		if (x[CW+1:CW-1] != {3{x[CW+1]}})
			r = x[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		else
			r = x[CW-1:0];
		return r;
	endfunction

	// scale a raw product: magnitude truncated, then saturated by sign
	function automatic logic [CW-1:0] fin(input logic signed [PW-1:0] p);
		logic          neg;
		logic [PW-1:0] mag;
		logic [PW-1:0] q;
		logic [PW-1:0] l;
		neg = p[PW-1];
		mag = neg ? (~p + PW'(1)) : p;
		q   = mag >> FRAC_BITS;
		l   = neg ? HALF : HALF - PW'(1);
		if (q > l)
			q = l;
		if (neg)
			q = ~q + PW'(1);
		return q[CW-1:0];
	endfunction

	function automatic logic signed [PW-1:0] mul(input logic [CW-1:0] x,
		input logic [CW-1:0] y);
		logic signed [PW-1:0] r;
		r = PW'($signed(x)) * PW'($signed(y));
		return r;
	endfunction

	function automatic logic signed [CW:0] ext1(input logic [CW-1:0] x);
		return $signed({x[CW-1], x});
	endfunction

	logic [3:0] valid_q;
	logic       valid_s5;
	logic [2:0][CW-1:0] ab_s1, ac_s1, qp_s1, ap_s1;
	logic [2:0][CW-1:0] ab_s2, ac_s2, qp_s2, ap_s2;
	logic [2:0][CW-1:0] ab_s3, ac_s3, qp_s3, ap_s3;
	logic [2:0][PW-1:0] np0_s2, np1_s2, ep0_s2, ep1_s2;
	logic [2:0][CW-1:0] n_s3, e_s3;
	logic [2:0][PW-1:0] dp_s4, tp_s4, vp_s4, wp_s4;
	logic               hit_s5, zero_s5;
	logic [CW-1:0]      tn_s5, d_s5;

	logic [CW-1:0]        d_c, tn_c, v_c, w_c, wn_c;
	logic signed [CW+1:0] dsum, tsum, vsum, wsum, vw;
	logic                 hit_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s5 <= 1'b0;
		end else if (ce) begin
			valid_q  <= {valid_q[2:0], in_valid};
			valid_s5 <= valid_q[3];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				ab_s1[i] <= sat1($signed({vb[i][CW-1], vb[i]}) - $signed({va[i][CW-1], va[i]}));
				ac_s1[i] <= sat1($signed({vc[i][CW-1], vc[i]}) - $signed({va[i][CW-1], va[i]}));
				qp_s1[i] <= sat1(-$signed({dir[i][CW-1], dir[i]}));
				ap_s1[i] <= sat1($signed({origin[i][CW-1], origin[i]})
					- $signed({va[i][CW-1], va[i]}));
			end
			// stage 2: raw products of both cross products
			for (int i = 0; i < 3; i++) begin
				np0_s2[i] <= mul(ab_s1[(i+1)%3], ac_s1[(i+2)%3]);
				np1_s2[i] <= mul(ab_s1[(i+2)%3], ac_s1[(i+1)%3]);
				ep0_s2[i] <= mul(qp_s1[(i+1)%3], ap_s1[(i+2)%3]);
				ep1_s2[i] <= mul(qp_s1[(i+2)%3], ap_s1[(i+1)%3]);
			end
			ab_s2 <= ab_s1; ac_s2 <= ac_s1; qp_s2 <= qp_s1; ap_s2 <= ap_s1;
			for (int i = 0; i < 3; i++) begin
				n_s3[i] <= sat1(ext1(fin(np0_s2[i])) - ext1(fin(np1_s2[i])));
				e_s3[i] <= sat1(ext1(fin(ep0_s2[i])) - ext1(fin(ep1_s2[i])));
			end
			ab_s3 <= ab_s2; ac_s3 <= ac_s2; qp_s3 <= qp_s2; ap_s3 <= ap_s2;
			// stage 4: raw products of the four dot products
			for (int i = 0; i < 3; i++) begin
				dp_s4[i] <= mul(qp_s3[i], n_s3[i]);
				tp_s4[i] <= mul(ap_s3[i], n_s3[i]);
				vp_s4[i] <= mul(ac_s3[i], e_s3[i]);
				wp_s4[i] <= mul(ab_s3[i], e_s3[i]);
			end
			hit_s5  <= hit_c;
			zero_s5 <= hit_c && (d_c == '0);
			tn_s5   <= tn_c;
			d_s5    <= d_c;
		end
	end

	function automatic logic signed [CW+1:0] ext2(input logic [CW-1:0] x);
		return $signed({{2{x[CW-1]}}, x});
	endfunction

	always_comb begin
		dsum = ext2(fin(dp_s4[0])) + ext2(fin(dp_s4[1])) + ext2(fin(dp_s4[2]));
		tsum = ext2(fin(tp_s4[0])) + ext2(fin(tp_s4[1])) + ext2(fin(tp_s4[2]));
		vsum = ext2(fin(vp_s4[0])) + ext2(fin(vp_s4[1])) + ext2(fin(vp_s4[2]));
		wsum = ext2(fin(wp_s4[0])) + ext2(fin(wp_s4[1])) + ext2(fin(wp_s4[2]));
		d_c  = sat2(dsum);
		tn_c = sat2(tsum);
		v_c  = sat2(vsum);
		wn_c = sat2(wsum);
		w_c  = sat1(-$signed({wn_c[CW-1], wn_c}));
		vw   = ext2(v_c) + ext2(w_c);
		hit_c = (allow_backface || ($signed(d_c) > 0))
			&& !tn_c[CW-1] && !v_c[CW-1] && !w_c[CW-1]
			&& !(vw > ext2(d_c));
	end

	assign flags = '{valid: valid_s5, hit: hit_s5, zero_div: zero_s5};
	assign num   = tn_s5;
	assign den   = d_s5;

endmodule

FILE: rtl/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider, one quotient bit per stage, for
// t = num * 2^FRAC_BITS / den with saturation; final stage is the output reg.
// ----------------------------------------------------------------------------
module rti_div import rti_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   ce,
	input  geom_flags_t            in_flags,
	input  logic [COORD_WIDTH-1:0] num,
	input  logic [COORD_WIDTH-1:0] den,
	output geom_flags_t            out_flags,
	output logic [COORD_WIDTH-1:0] distance
);

	localparam int CW = COORD_WIDTH;
	localparam int QW = CW - 1 + FRAC_BITS;
	localparam int NS = QW;

	// per stage: remainder, pending dividend bits, quotient, divisor
	logic [NS:1]        vld_q;
	geom_flags_t        flg_q [1:NS];
	logic [CW-1:0]      rem_q [1:NS];
	logic [QW-1:0]      dvd_q [1:NS];
	logic [QW-1:0]      quo_q [1:NS];
	logic [CW-2:0]      dsr_q [1:NS];
	logic [CW-1:0]      dist_q;

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic          vld_i;
		geom_flags_t   flg_i;
		logic [CW-1:0] rem_i;
		logic [QW-1:0] dvd_i;
		logic [QW-1:0] quo_i;
		logic [CW-2:0] dsr_i;
		logic [CW-1:0] trial;
		logic          take;

		if (k == 0) begin : g_first
			assign vld_i = in_flags.valid;
			assign flg_i = in_flags;
			assign rem_i = '0;
			assign dvd_i = {num[CW-2:0], {FRAC_BITS{1'b0}}};
			assign quo_i = '0;
			assign dsr_i = den[CW-2:0];
		end else begin : g_next
			assign vld_i = vld_q[k];
			assign flg_i = flg_q[k];
			assign rem_i = rem_q[k];
			assign dvd_i = dvd_q[k];
			assign quo_i = quo_q[k];
			assign dsr_i = dsr_q[k];
		end

		assign trial = {rem_i[CW-2:0], dvd_i[QW-1]};
		assign take  = trial >= {1'b0, dsr_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_q[k+1] <= 1'b0;
			else if (ce)
				vld_q[k+1] <= vld_i;
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				flg_q[k+1] <= flg_i;
				rem_q[k+1] <= take ? trial - {1'b0, dsr_i} : trial;
				dvd_q[k+1] <= {dvd_i[QW-2:0], 1'b0};
				quo_q[k+1] <= {quo_i[QW-2:0], take};
				dsr_q[k+1] <= dsr_i;
			end
		end
	end

	logic          out_vld_q;
	geom_flags_t   out_flg_q;
	logic [CW-1:0] dist_c;

	always_comb begin
		if (!flg_q[NS].hit)
			dist_c = '0;
		else if (flg_q[NS].zero_div || (quo_q[NS][QW-1:CW-1] != '0))
			dist_c = {1'b0, {(CW-1){1'b1}}};
		else
			dist_c = quo_q[NS][CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (ce)
			out_vld_q <= vld_q[NS];
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			out_flg_q <= flg_q[NS];
			dist_q    <= dist_c;
		end
	end

	assign out_flags = '{valid: out_vld_q, hit: out_flg_q.hit,
		zero_div: out_flg_q.hit && out_flg_q.zero_div};
	assign distance  = dist_q;

endmodule
